// File: rtl/fta_pkg.sv
// Shared types and constants for the fan tachometer auto-range unit.
`default_nettype none
package fta_pkg;

   localparam int NUM_FANS = 2;

   localparam int RPM_W   = 21;
   localparam int CNT_W   = 8;
   localparam int EXP_W   = 2;
   localparam int SCALE_W = CNT_W + 3;

   localparam logic [RPM_W-1:0] TACH_CLOCK   = 21'd1350000;
   localparam logic [CNT_W-1:0] CNT_DISABLED = 8'd255;
   localparam logic [CNT_W-1:0] CNT_FLOOR    = 8'd254;
   localparam logic [CNT_W-1:0] CNT_CEIL     = 8'd192;
   localparam logic [EXP_W-1:0] EXP_MAX      = 2'd3;
   localparam logic [RPM_W-1:0] RPM_LOW      = RPM_W'(1350000 / (8 * 254));

   localparam logic OP_SET_LIMIT = 1'b0;
   localparam logic OP_MEASURE   = 1'b1;

   typedef enum logic [1:0] {
      SEL_LIMIT,
      SEL_SPEED,
      SEL_LSPEED
   } fta_sel_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DECIDE,
      ST_LIM_WAIT,
      ST_SPD_START,
      ST_SPD_WAIT,
      ST_LSP_START,
      ST_LSP_WAIT,
      ST_EMIT
   } fta_state_type;

   typedef struct packed {
      logic        load;
      logic        apply;
      logic        div_go;
      fta_sel_type sel;
      logic        save_speed;
      logic        save_lspeed;
      logic        emit;
   } fta_cmd_type;

   typedef struct packed {
      logic op;
      logic needs_div;
      logic div_done;
   } fta_status_type;

endpackage
`default_nettype wire

// File: rtl/fta_div.sv
// Restoring divider, one quotient bit per cycle.
`default_nettype none
module fta_div
   import fta_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             go,
   input  wire logic [RPM_W-1:0] dividend,
   input  wire logic [RPM_W-1:0] divisor,
   output logic                  done,
   output logic      [RPM_W-1:0] quotient
);

   localparam int STEP_W = $clog2(RPM_W);

   logic [RPM_W-1:0]  num_ff, num_in;
   logic [RPM_W-1:0]  den_ff;
   logic [RPM_W-1:0]  rem_ff, rem_in;
   logic [STEP_W-1:0] step_ff;
   logic              run_ff;
   logic              done_ff;

   logic [RPM_W:0]   trial;
   logic [RPM_W+1:0] diff;
   logic             fits;

   always_comb begin
      trial  = {rem_ff, num_ff[RPM_W-1]};
      diff   = {1'b0, trial} - {2'b00, den_ff};
      fits   = !diff[RPM_W+1];
      rem_in = fits ? diff[RPM_W-1:0] : trial[RPM_W-1:0];
      num_in = {num_ff[RPM_W-2:0], fits};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         // strobe done on the last quotient bit
         done_ff <= !go && run_ff && (step_ff == '0);
         if (go) begin
            run_ff  <= 1'b1;
            step_ff <= STEP_W'(RPM_W - 1);
            num_ff  <= dividend;
            den_ff  <= divisor;
            rem_ff  <= '0;
         end else if (run_ff) begin
            num_ff  <= num_in;
            rem_ff  <= rem_in;
            step_ff <= step_ff - 1'b1;
            if (step_ff == '0) begin
               run_ff <= 1'b0;
            end
         end
      end
   end

   assign done     = done_ff;
   assign quotient = num_ff;

endmodule
`default_nettype wire

// File: rtl/fta_dp.sv
// Datapath: per-fan state, limit and overflow rules, divider and result registers.
`default_nettype none
module fta_dp
   import fta_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire fta_cmd_type      cmd,
   output fta_status_type        status,
   input  wire logic             req_op,
   input  wire logic             req_fan_index,
   input  wire logic [RPM_W-1:0] req_limit_rpm,
   input  wire logic [CNT_W-1:0] req_tach_count,
   output logic                  rsp_valid,
   output logic      [RPM_W-1:0] rsp_speed_rpm,
   output logic                  rsp_speed_error,
   output logic      [RPM_W-1:0] rsp_limit_speed_rpm,
   output logic      [CNT_W-1:0] rsp_limit_count,
   output logic      [EXP_W-1:0] rsp_divider_exp,
   output logic                  rsp_divider_changed
);

   logic [EXP_W-1:0] div_exp_ff   [NUM_FANS];
   logic [CNT_W-1:0] limit_cnt_ff [NUM_FANS];
   logic [CNT_W-1:0] last_cnt_ff  [NUM_FANS];
   logic             primed_ff    [NUM_FANS];

   logic             op_ff;
   logic             fan_ff;
   logic [RPM_W-1:0] rpm_ff;
   logic [CNT_W-1:0] tach_ff;
   logic [EXP_W-1:0] old_exp_ff;

   logic             valid_ff;
   logic [RPM_W-1:0] speed_ff;
   logic             error_ff;
   logic [RPM_W-1:0] lspeed_ff;
   logic [CNT_W-1:0] lcount_ff;
   logic [EXP_W-1:0] dexp_ff;
   logic             changed_ff;

   logic [EXP_W-1:0] cur_exp;
   logic [CNT_W-1:0] cur_lim;
   logic [CNT_W-1:0] cur_last;
   logic [EXP_W-1:0] exp_in;
   logic [CNT_W-1:0] lim_in;
   logic [CNT_W-1:0] last_in;

   logic             div_done;
   logic [RPM_W-1:0] quotient;
   logic [RPM_W-1:0] div_num;
   logic [RPM_W-1:0] div_den;
   logic [SCALE_W-1:0] scaled;
   logic [CNT_W-1:0]   scale_src;

   logic [SCALE_W-1:0] halve_cnt;
   logic [EXP_W-1:0]   halve_exp;

   assign cur_exp  = div_exp_ff[fan_ff];
   assign cur_lim  = limit_cnt_ff[fan_ff];
   assign cur_last = last_cnt_ff[fan_ff];

   // limit count from the quotient: halve while above the ceiling, at most three times; a zero count becomes one
   always_comb begin
      halve_cnt = quotient[SCALE_W-1:0];
      halve_exp = '0;
      for (int i = 0; i < 3; i++) begin
         if (halve_cnt > SCALE_W'(CNT_CEIL)) begin
            halve_cnt = halve_cnt >> 1;
            halve_exp = halve_exp + 1'b1;
         end
      end
      if (halve_cnt == '0) begin
         halve_cnt = SCALE_W'(1);
      end
   end

   always_comb begin
      exp_in  = cur_exp;
      lim_in  = cur_lim;
      last_in = cur_last;
      if (op_ff == OP_SET_LIMIT) begin
         if (rpm_ff == '0) begin
            lim_in = CNT_DISABLED;
         end else if (rpm_ff < RPM_LOW) begin
            exp_in = EXP_MAX;
            lim_in = CNT_FLOOR;
         end else begin
            exp_in = halve_exp;
            lim_in = halve_cnt[CNT_W-1:0];
         end
      end else begin
         last_in = tach_ff;
         // overflow on a primed fan: widen the divider, follow with the limit
         if (primed_ff[fan_ff] && tach_ff == CNT_DISABLED && cur_exp < EXP_MAX) begin
            exp_in = cur_exp + 1'b1;
            if (cur_lim < CNT_DISABLED && cur_lim >= CNT_W'(2)) begin
               lim_in = cur_lim >> 1;
            end
         end
      end
   end

   always_comb begin
      scale_src = (cmd.sel == SEL_LSPEED) ? cur_lim : cur_last;
      scaled    = SCALE_W'(scale_src) << cur_exp;
      case (cmd.sel)
         SEL_LIMIT: begin
            div_num = TACH_CLOCK;
            div_den = rpm_ff;
         end
         SEL_SPEED, SEL_LSPEED: begin
            div_num = TACH_CLOCK + RPM_W'(scaled >> 1);
            div_den = RPM_W'(scaled);
         end
         default: begin
            div_num = TACH_CLOCK;
            div_den = rpm_ff;
         end
      endcase
   end

   fta_div u_div (
      .clock    (clock),
      .reset    (reset),
      .go       (cmd.div_go),
      .dividend (div_num),
      .divisor  (div_den),
      .done     (div_done),
      .quotient (quotient)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int f = 0; f < NUM_FANS; f++) begin
            div_exp_ff[f]   <= '0;
            limit_cnt_ff[f] <= CNT_DISABLED;
            last_cnt_ff[f]  <= CNT_DISABLED;
            primed_ff[f]    <= 1'b0;
         end
      end else if (cmd.apply) begin
         div_exp_ff[fan_ff]   <= exp_in;
         limit_cnt_ff[fan_ff] <= lim_in;
         last_cnt_ff[fan_ff]  <= last_in;
         if (op_ff == OP_MEASURE) begin
            primed_ff[fan_ff] <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff      <= req_op;
         fan_ff     <= req_fan_index;
         rpm_ff     <= req_limit_rpm;
         tach_ff    <= req_tach_count;
         old_exp_ff <= div_exp_ff[req_fan_index];
      end
      if (cmd.save_speed) begin
         error_ff <= (cur_last == '0);
         speed_ff <= (cur_last == '0 || cur_last == CNT_DISABLED) ? '0 : quotient;
      end
      if (cmd.save_lspeed) begin
         lspeed_ff <= (cur_lim == '0 || cur_lim == CNT_DISABLED) ? '0 : quotient;
      end
      if (cmd.emit) begin
         lcount_ff  <= cur_lim;
         dexp_ff    <= cur_exp;
         changed_ff <= (cur_exp != old_exp_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= cmd.emit;
      end
   end

   assign status.op        = op_ff;
   assign status.needs_div = (rpm_ff >= RPM_LOW);
   assign status.div_done  = div_done;

   assign rsp_valid           = valid_ff;
   assign rsp_speed_rpm       = speed_ff;
   assign rsp_speed_error     = error_ff;
   assign rsp_limit_speed_rpm = lspeed_ff;
   assign rsp_limit_count     = lcount_ff;
   assign rsp_divider_exp     = dexp_ff;
   assign rsp_divider_changed = changed_ff;

endmodule
`default_nettype wire

// File: rtl/fta_ctrl.sv
// Controller: sequences the limit division, state update and the two speed divisions.
`default_nettype none
module fta_ctrl
   import fta_pkg::*;
(
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           start,
   output logic                busy,
   input  wire fta_status_type status,
   output fta_cmd_type         cmd
);

   fta_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      cmd.sel  = SEL_LIMIT;
      busy     = 1'b1;
      case (state_ff)
         ST_IDLE: begin
            busy = 1'b0;
            if (start) begin
               cmd.load = 1'b1;
               state_in = ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            if (status.op == OP_SET_LIMIT && status.needs_div) begin
               cmd.div_go = 1'b1;
               cmd.sel    = SEL_LIMIT;
               state_in   = ST_LIM_WAIT;
            end else begin
               cmd.apply = 1'b1;
               state_in  = ST_SPD_START;
            end
         end
         ST_LIM_WAIT: begin
            if (status.div_done) begin
               cmd.apply = 1'b1;
               state_in  = ST_SPD_START;
            end
         end
         ST_SPD_START: begin
            cmd.div_go = 1'b1;
            cmd.sel    = SEL_SPEED;
            state_in   = ST_SPD_WAIT;
         end
         ST_SPD_WAIT: begin
            cmd.sel = SEL_SPEED;
            if (status.div_done) begin
               cmd.save_speed = 1'b1;
               state_in       = ST_LSP_START;
            end
         end
         ST_LSP_START: begin
            cmd.div_go = 1'b1;
            cmd.sel    = SEL_LSPEED;
            state_in   = ST_LSP_WAIT;
         end
         ST_LSP_WAIT: begin
            cmd.sel = SEL_LSPEED;
            if (status.div_done) begin
               cmd.save_lspeed = 1'b1;
               state_in        = ST_EMIT;
            end
         end
         ST_EMIT: begin
            cmd.emit = 1'b1;
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule
`default_nettype wire

// File: rtl/fan_tach_autorange_unit.sv
// Top level of the fan tachometer auto-range unit.
// Every request runs two speed divisions on the shared divider; a set-limit request with an
// rpm of 664 or more first runs a limit division on it as well.
// Throughput: one request at a time; the next is accepted in the cycle the result strobes.
// Results strobe on rsp_valid for one cycle and cannot be stalled.
// Reset: synchronous; every fan returns to divider 0, limit and last count 255, unprimed.
`default_nettype none
module fan_tach_autorange_unit
   import fta_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   output logic                  busy,
   input  wire logic             req_op,
   input  wire logic             req_fan_index,
   input  wire logic [RPM_W-1:0] req_limit_rpm,
   input  wire logic [CNT_W-1:0] req_tach_count,
   output logic                  rsp_valid,
   output logic      [RPM_W-1:0] rsp_speed_rpm,
   output logic                  rsp_speed_error,
   output logic      [RPM_W-1:0] rsp_limit_speed_rpm,
   output logic      [CNT_W-1:0] rsp_limit_count,
   output logic      [EXP_W-1:0] rsp_divider_exp,
   output logic                  rsp_divider_changed
);

   fta_cmd_type    cmd;
   fta_status_type status;

   fta_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .busy   (busy),
      .status (status),
      .cmd    (cmd)
   );

   fta_dp u_dp (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (cmd),
      .status              (status),
      .req_op              (req_op),
      .req_fan_index       (req_fan_index),
      .req_limit_rpm       (req_limit_rpm),
      .req_tach_count      (req_tach_count),
      .rsp_valid           (rsp_valid),
      .rsp_speed_rpm       (rsp_speed_rpm),
      .rsp_speed_error     (rsp_speed_error),
      .rsp_limit_speed_rpm (rsp_limit_speed_rpm),
      .rsp_limit_count     (rsp_limit_count),
      .rsp_divider_exp     (rsp_divider_exp),
      .rsp_divider_changed (rsp_divider_changed)
   );

   a_strobe_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe held for more than one cycle");

   a_strobe_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("result strobed while a request is still in work");

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("accepted request did not raise busy");

   a_error_speed: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_speed_error) |-> (rsp_speed_rpm == '0))
      else $error("speed reported alongside a zero count");

endmodule
`default_nettype wire

// File: tb/tb.sv
// Self-checking testbench for the fan tachometer auto-range unit.
`timescale 1ns / 100ps
module tb
   import fta_pkg::*;
;

   typedef struct packed {
      logic             op;
      logic             fan;
      logic [RPM_W-1:0] rpm;
      logic [CNT_W-1:0] cnt;
   } fan_request_type;

   typedef struct packed {
      logic [RPM_W-1:0] speed_rpm;
      logic             speed_error;
      logic [RPM_W-1:0] limit_speed_rpm;
      logic [CNT_W-1:0] limit_count;
      logic [EXP_W-1:0] divider_exp;
      logic             divider_changed;
   } fan_reading_type;

   logic             clock;
   logic             reset;
   logic             start = 1'b0;
   logic             busy;
   logic             req_op = OP_MEASURE;
   logic             req_fan_index = 1'b0;
   logic [RPM_W-1:0] req_limit_rpm = '0;
   logic [CNT_W-1:0] req_tach_count = '0;
   logic             rsp_valid;
   logic [RPM_W-1:0] rsp_speed_rpm;
   logic             rsp_speed_error;
   logic [RPM_W-1:0] rsp_limit_speed_rpm;
   logic [CNT_W-1:0] rsp_limit_count;
   logic [EXP_W-1:0] rsp_divider_exp;
   logic             rsp_divider_changed;

   fan_request_type request_backlog[$];
   fan_reading_type expected_readings[$];
   fan_request_type drive_item;
   int unsigned     burst_left = 1;
   int unsigned     gap_left = 0;
   int unsigned     mismatch_count = 0;

   // predicted per-fan state
   logic [EXP_W-1:0] fan_div_exp[NUM_FANS];
   logic [CNT_W-1:0] fan_limit_cnt[NUM_FANS];
   logic [CNT_W-1:0] fan_last_cnt[NUM_FANS];
   logic             fan_primed[NUM_FANS];

   fan_tach_autorange_unit DUT (
      .clock               (clock),
      .reset               (reset),
      .start               (start),
      .busy                (busy),
      .req_op              (req_op),
      .req_fan_index       (req_fan_index),
      .req_limit_rpm       (req_limit_rpm),
      .req_tach_count      (req_tach_count),
      .rsp_valid           (rsp_valid),
      .rsp_speed_rpm       (rsp_speed_rpm),
      .rsp_speed_error     (rsp_speed_error),
      .rsp_limit_speed_rpm (rsp_limit_speed_rpm),
      .rsp_limit_count     (rsp_limit_count),
      .rsp_divider_exp     (rsp_divider_exp),
      .rsp_divider_changed (rsp_divider_changed)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   initial begin
      reset = 1'b1;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
   end

   initial begin
      #10_000_000;
      $display("FAIL fan_tach_autorange_unit");
      $finish;
   end

   // rounded 1350000 / (count * 2^exp)
   function automatic logic [RPM_W-1:0] count_to_rpm(logic [CNT_W-1:0] c,
                                                     logic [EXP_W-1:0] e);
      int unsigned d;
      d = 32'(c);
      d = d << e;
      return RPM_W'((TACH_CLOCK + d / 2) / d);
   endfunction

   function automatic fan_reading_type fan_model_step(fan_request_type rq);
      fan_reading_type  rd;
      logic [EXP_W-1:0] old_exp;
      int unsigned      cnt;
      int unsigned      e;
      logic [CNT_W-1:0] cur;
      logic [CNT_W-1:0] lim;
      rd = '0;
      old_exp = fan_div_exp[rq.fan];
      if (rq.op == OP_SET_LIMIT) begin
         if (rq.rpm == 0) begin
            fan_limit_cnt[rq.fan] = CNT_DISABLED;
         end else if (rq.rpm < RPM_LOW) begin
            fan_div_exp[rq.fan] = EXP_MAX;
            fan_limit_cnt[rq.fan] = CNT_FLOOR;
         end else begin
            cnt = 32'(TACH_CLOCK / rq.rpm);
            e = 0;
            // halve into range, one divider step per halving
            while (cnt > CNT_CEIL && e < EXP_MAX) begin
               e++;
               cnt = cnt / 2;
            end
            if (cnt == 0)
               cnt = 1;
            fan_div_exp[rq.fan] = EXP_W'(e);
            fan_limit_cnt[rq.fan] = CNT_W'(cnt);
         end
      end else begin
         fan_last_cnt[rq.fan] = rq.cnt;
         if (fan_primed[rq.fan] && rq.cnt == CNT_DISABLED && fan_div_exp[rq.fan] < EXP_MAX) begin
            fan_div_exp[rq.fan] = fan_div_exp[rq.fan] + 1'b1;
            if (fan_limit_cnt[rq.fan] < CNT_DISABLED && fan_limit_cnt[rq.fan] >= 2)
               fan_limit_cnt[rq.fan] = fan_limit_cnt[rq.fan] >> 1;
         end
         fan_primed[rq.fan] = 1'b1;
      end
      cur = fan_last_cnt[rq.fan];
      lim = fan_limit_cnt[rq.fan];
      if (cur == 0)
         rd.speed_error = 1'b1;
      else if (cur != CNT_DISABLED)
         rd.speed_rpm = count_to_rpm(cur, fan_div_exp[rq.fan]);
      if (lim != 0 && lim != CNT_DISABLED)
         rd.limit_speed_rpm = count_to_rpm(lim, fan_div_exp[rq.fan]);
      rd.limit_count = lim;
      rd.divider_exp = fan_div_exp[rq.fan];
      rd.divider_changed = (fan_div_exp[rq.fan] != old_exp);
      return rd;
   endfunction

   task automatic queue_request(logic op, logic fan, logic [RPM_W-1:0] rpm,
                                logic [CNT_W-1:0] cnt);
      fan_request_type rq;
      rq.op = op;
      rq.fan = fan;
      rq.rpm = rpm;
      rq.cnt = cnt;
      request_backlog.push_back(rq);
   endtask

   task automatic note_mismatch(string what, int unsigned got, int unsigned want);
      mismatch_count++;
      // keep the log short when the block is badly off
      if (mismatch_count <= 100)
         $display("%0t: mismatch on %s: got %0d, expected %0d", $time, what, got, want);
   endtask

   // driver: bursts of requests separated by random gaps
   always @(posedge clock) begin
      logic take_next;
      if (reset) begin
         start <= 1'b0;
      end else begin
         take_next = 1'b0;
         if (start && !busy) begin
            expected_readings.push_back(fan_model_step(drive_item));
            take_next = 1'b1;
         end else if (!start) begin
            take_next = 1'b1;
         end
         if (take_next) begin
            if (gap_left > 0) begin
               gap_left--;
               start <= 1'b0;
            end else if (request_backlog.size() > 0) begin
               drive_item = request_backlog.pop_front();
               req_op <= drive_item.op;
               req_fan_index <= drive_item.fan;
               req_limit_rpm <= drive_item.rpm;
               req_tach_count <= drive_item.cnt;
               start <= 1'b1;
               if (burst_left <= 1) begin
                  burst_left = $urandom_range(1, 12);
                  gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 75);
               end else begin
                  burst_left--;
               end
            end else begin
               start <= 1'b0;
            end
         end
      end
   end

   // monitor: compare each strobed result with the oldest prediction
   always @(posedge clock) begin
      fan_reading_type want;
      if (!reset && rsp_valid) begin
         if (expected_readings.size() == 0) begin
            note_mismatch("result with no request pending", 1, 0);
         end else begin
            want = expected_readings.pop_front();
            if (rsp_speed_rpm !== want.speed_rpm)
               note_mismatch("speed_rpm", rsp_speed_rpm, want.speed_rpm);
            if (rsp_speed_error !== want.speed_error)
               note_mismatch("speed_error", rsp_speed_error, want.speed_error);
            if (rsp_limit_speed_rpm !== want.limit_speed_rpm)
               note_mismatch("limit_speed_rpm", rsp_limit_speed_rpm, want.limit_speed_rpm);
            if (rsp_limit_count !== want.limit_count)
               note_mismatch("limit_count", rsp_limit_count, want.limit_count);
            if (rsp_divider_exp !== want.divider_exp)
               note_mismatch("divider_exp", rsp_divider_exp, want.divider_exp);
            if (rsp_divider_changed !== want.divider_changed)
               note_mismatch("divider_changed", rsp_divider_changed, want.divider_changed);
         end
      end
   end

   initial begin
      int unsigned      n;
      logic             op;
      logic             fan;
      logic [RPM_W-1:0] rpm;
      logic [CNT_W-1:0] cnt;
      int unsigned      wait_cycles;

      for (int i = 0; i < NUM_FANS; i++) begin
         fan_div_exp[i] = '0;
         fan_limit_cnt[i] = CNT_DISABLED;
         fan_last_cnt[i] = CNT_DISABLED;
         fan_primed[i] = 1'b0;
      end

      // directed: first measurement, overflow stepping, limit boundaries
      queue_request(OP_MEASURE,   1'b0, 21'd0,       CNT_DISABLED);
      queue_request(OP_MEASURE,   1'b0, 21'd0,       CNT_DISABLED);
      queue_request(OP_SET_LIMIT, 1'b0, 21'd0,       8'd0);
      queue_request(OP_SET_LIMIT, 1'b0, 21'd1,       8'd0);
      queue_request(OP_SET_LIMIT, 1'b0, RPM_LOW - 1, 8'd0);
      queue_request(OP_SET_LIMIT, 1'b0, RPM_LOW,     8'd0);
      queue_request(OP_SET_LIMIT, 1'b0, TACH_CLOCK,  8'd0);
      queue_request(OP_MEASURE,   1'b0, 21'd0,       CNT_DISABLED);
      queue_request(OP_SET_LIMIT, 1'b0, 21'h1FFFFF,  8'hFF);
      queue_request(OP_SET_LIMIT, 1'b1, 21'd7031,    8'd0);
      queue_request(OP_SET_LIMIT, 1'b1, 21'd6994,    8'd0);
      queue_request(OP_MEASURE,   1'b1, 21'd0,       8'd0);
      queue_request(OP_MEASURE,   1'b1, 21'd0,       8'd1);
      queue_request(OP_MEASURE,   1'b1, 21'd0,       CNT_FLOOR);
      queue_request(OP_MEASURE,   1'b1, 21'd0,       CNT_DISABLED);
      queue_request(OP_MEASURE,   1'b1, 21'd0,       CNT_DISABLED);
      queue_request(OP_MEASURE,   1'b1, 21'd0,       CNT_DISABLED);
      queue_request(OP_SET_LIMIT, 1'b1, 21'd1000,    8'd0);
      queue_request(OP_MEASURE,   1'b0, 21'd0,       8'd0);
      queue_request(OP_MEASURE,   1'b0, 21'd0,       8'd128);
      queue_request(OP_SET_LIMIT, 1'b1, 21'h100000,  8'd0);
      queue_request(OP_MEASURE,   1'b1, 21'd0,       8'd170);
      queue_request(OP_MEASURE,   1'b1, 21'd0,       8'd85);
      queue_request(OP_SET_LIMIT, 1'b0, 21'd664,     8'd0);

      // random: mostly measurements with frequent overflows, limits across all ranges
      for (n = 0; n < 1030; n++) begin
         op = ($urandom_range(0, 99) < 35) ? OP_SET_LIMIT : OP_MEASURE;
         fan = 1'($urandom_range(0, 1));
         case ($urandom_range(0, 9))
            0: rpm = 21'd0;
            1: rpm = RPM_W'($urandom_range(1, RPM_LOW - 1));
            2: rpm = RPM_W'($urandom_range(RPM_LOW - 4, RPM_LOW + 6));
            3: rpm = RPM_W'($urandom_range(RPM_LOW, 7100));
            4, 5, 6: rpm = RPM_W'($urandom_range(RPM_LOW, TACH_CLOCK));
            7: rpm = RPM_W'($urandom_range(0, 21'h1FFFFF));
            8: rpm = RPM_W'(TACH_CLOCK - $urandom_range(0, 200));
            default: rpm = RPM_W'(TACH_CLOCK / $urandom_range(1, 255));
         endcase
         case ($urandom_range(0, 19))
            0: cnt = 8'd0;
            1, 2, 3, 4, 5, 6, 7: cnt = CNT_DISABLED;
            default: cnt = CNT_W'($urandom_range(0, 255));
         endcase
         queue_request(op, fan, rpm, cnt);
      end

      @(posedge clock);
      while (request_backlog.size() > 0 || start)
         @(posedge clock);
      while (expected_readings.size() > 0)
         @(posedge clock);
      // drain: catch any stray strobe after the last result
      wait_cycles = 120;
      repeat (wait_cycles) @(posedge clock);

      if (mismatch_count == 0)
         $display("PASS fan_tach_autorange_unit");
      else
         $display("FAIL fan_tach_autorange_unit");
      $finish;
   end

endmodule
